// ===== rtl/i2p_pkg.sv =====
// Shared types and constants for the infix to postfix converter.
// The front, command queue, back and top level all use this package.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Default operator stack depth and the most results one character may cause.
  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 34;

  // Character constants.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Operator stack codes.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LPAREN = 3'd1;
  localparam logic [2:0] OP_PLUS   = 3'd2;
  localparam logic [2:0] OP_MINUS  = 3'd3;
  localparam logic [2:0] OP_TIMES  = 3'd4;
  localparam logic [2:0] OP_DIVIDE = 3'd5;

  // What the back end has to do for one character.
  typedef enum logic [2:0] {
    KIND_CLOSE  = 3'd0,
    KIND_TOKEN  = 3'd1,
    KIND_LPAREN = 3'd2,
    KIND_RPAREN = 3'd3,
    KIND_OP     = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter (shunting-yard).
// Depends on i2p_pkg, i2p_front, i2p_cmdq and i2p_back.
//
//   Channel  Ports                                              Direction
//   input    in_valid, in_stall, in_char_in, in_last_char       request in
//   result   out_valid, out_stall, out_char_out,                request out
//            out_end_of_expression, out_stack_overflow
//
// A request enters the two-entry queue in its cycle of acceptance. The back end runs
// a token through IDLE-HEAD-TAIL, others through IDLE-HEAD-BODY-TAIL, with
// POPCH-POPSP-BODY per popped operator; a last request adds FLUSH-POPCH-POPSP per
// stack entry left and FLUSH for the terminator. Reset is synchronous and active low
// and empties the queue, the stack and the output register. A result stall holds the
// back end only at steps that write a result; the queue keeps accepting until full.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic            out_end_of_expression,
  output logic            out_stack_overflow
);

  // Classified commands travel from the front end to the back end in this queue.
  i2p_pkg::cmd_t push_cmd;
  i2p_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;

  // The front end decodes each byte into a command kind and operator code.
  i2p_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_in   (in_char_in),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // The queue lets the front end keep taking requests while the back end
  // is busy popping operators or waiting on a stalled result channel.
  i2p_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // The back end owns the operator stack, the open-token and overflow flags,
  // and a registered result stage that the downstream side drains.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_cmd                 (head_cmd),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_char_out          (out_char_out),
    .out_end_of_expression (out_end_of_expression),
    .out_stack_overflow    (out_stack_overflow)
  );

endmodule

`default_nettype wire

// ===== rtl/i2p_front.sv =====
// Front end: accepts input characters and classifies them into commands.
// Depends on i2p_pkg; feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none

module i2p_front (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last_char,
  input  wire logic        q_full,
  output logic             q_push,
  output i2p_pkg::cmd_t    q_cmd
);

  logic is_space;
  logic is_token;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    is_space = (in_char_in == i2p_pkg::CH_SPACE) ||
               ((in_char_in >= 8'd9) && (in_char_in <= 8'd13));
    is_token = ((in_char_in >= 8'h30) && (in_char_in <= 8'h39)) ||
               ((in_char_in >= 8'h41) && (in_char_in <= 8'h5A)) ||
               ((in_char_in >= 8'h61) && (in_char_in <= 8'h7A)) ||
               (in_char_in == i2p_pkg::CH_DOT);

    q_cmd.kind = i2p_pkg::KIND_CLOSE;
    q_cmd.op   = i2p_pkg::OP_NONE;
    q_cmd.ch   = in_char_in;
    q_cmd.last = in_last_char;

    if (is_space) begin
      q_cmd.kind = i2p_pkg::KIND_CLOSE;
    end else if (is_token) begin
      q_cmd.kind = i2p_pkg::KIND_TOKEN;
    end else begin
      case (in_char_in)
        i2p_pkg::CH_LPAREN: begin
          q_cmd.kind = i2p_pkg::KIND_LPAREN;
          q_cmd.op   = i2p_pkg::OP_LPAREN;
        end
        i2p_pkg::CH_RPAREN: q_cmd.kind = i2p_pkg::KIND_RPAREN;
        i2p_pkg::CH_PLUS: begin
          q_cmd.kind = i2p_pkg::KIND_OP;
          q_cmd.op   = i2p_pkg::OP_PLUS;
        end
        i2p_pkg::CH_MINUS: begin
          q_cmd.kind = i2p_pkg::KIND_OP;
          q_cmd.op   = i2p_pkg::OP_MINUS;
        end
        i2p_pkg::CH_TIMES: begin
          q_cmd.kind = i2p_pkg::KIND_OP;
          q_cmd.op   = i2p_pkg::OP_TIMES;
        end
        i2p_pkg::CH_DIVIDE: begin
          q_cmd.kind = i2p_pkg::KIND_OP;
          q_cmd.op   = i2p_pkg::OP_DIVIDE;
        end
        default: q_cmd.kind = i2p_pkg::KIND_CLOSE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2p_cmdq.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on i2p_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module i2p_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire i2p_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output i2p_pkg::cmd_t      head_cmd
);

  i2p_pkg::cmd_t entries [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2p_back.sv =====
// Back end: sequencer with the operator stack and the output register.
// Depends on i2p_pkg; takes commands from the command queue.
`timescale 1ns / 1ps
`default_nettype none

module i2p_back #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire i2p_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char_out,
  output logic               out_end_of_expression,
  output logic               out_stack_overflow
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int ECNT_W = $clog2(i2p_pkg::MAX_RESULTS);
  localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(STACK_DEPTH);
  localparam logic [ECNT_W-1:0] CHAR_CAP = ECNT_W'(i2p_pkg::MAX_RESULTS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_BODY  = 7'b0000100,
    S_POPCH = 7'b0001000,
    S_POPSP = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    case (code)
      i2p_pkg::OP_LPAREN: code_char = i2p_pkg::CH_LPAREN;
      i2p_pkg::OP_PLUS:   code_char = i2p_pkg::CH_PLUS;
      i2p_pkg::OP_MINUS:  code_char = i2p_pkg::CH_MINUS;
      i2p_pkg::OP_TIMES:  code_char = i2p_pkg::CH_TIMES;
      i2p_pkg::OP_DIVIDE: code_char = i2p_pkg::CH_DIVIDE;
      default:            code_char = i2p_pkg::CH_NUL;
    endcase
  endfunction

  function automatic logic [1:0] prec_of(input logic [2:0] code);
    case (code)
      i2p_pkg::OP_PLUS, i2p_pkg::OP_MINUS:  prec_of = 2'd1;
      i2p_pkg::OP_TIMES, i2p_pkg::OP_DIVIDE: prec_of = 2'd2;
      default:                               prec_of = 2'd0;
    endcase
  endfunction

  logic [2:0] stack_mem [STACK_DEPTH];

  state_t            state_r, state_nxt;
  i2p_pkg::cmd_t     cur_r, cur_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              tok_open_r, tok_open_nxt;
  logic              ovf_r, ovf_nxt;
  logic              flush_r, flush_nxt;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_eoe_r, out_eoe_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              emit_req;
  logic              emit_term;
  logic [7:0]        emit_char;
  logic              emit_ok;
  logic              out_free;
  logic              proceed;
  logic              load;
  logic              push_en;
  logic [2:0]        push_code;
  logic [CNT_W-1:0]  top_pos;
  logic [2:0]        top_code;
  logic              stack_empty;

  assign top_pos     = count_r - CNT_W'(1);
  assign top_code    = stack_mem[top_pos[IDX_W-1:0]];
  assign stack_empty = (count_r == '0);
  assign out_free    = !out_valid_r || !out_stall;
  assign proceed     = !emit_req || out_free;
  // Character results past the per-item cap are dropped; the terminator always goes out.
  assign emit_ok     = emit_req && (emit_term || (ecnt_r < CHAR_CAP));
  assign load        = emit_ok && out_free;
  assign q_pop       = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    count_nxt    = count_r;
    tok_open_nxt = tok_open_r;
    ovf_nxt      = ovf_r;
    flush_nxt    = flush_r;
    ecnt_nxt     = ecnt_r;
    emit_req     = 1'b0;
    emit_term    = 1'b0;
    emit_char    = i2p_pkg::CH_SPACE;
    push_en      = 1'b0;
    push_code    = cur_r.op;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt   = q_cmd;
          ecnt_nxt  = '0;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (cur_r.kind == i2p_pkg::KIND_TOKEN) begin
          emit_req  = 1'b1;
          emit_char = cur_r.ch;
          if (proceed) begin
            tok_open_nxt = 1'b1;
            state_nxt    = S_TAIL;
          end
        end else begin
          emit_req = tok_open_r;
          if (proceed) begin
            tok_open_nxt = 1'b0;
            state_nxt    = S_BODY;
          end
        end
      end
      S_BODY: begin
        case (cur_r.kind)
          i2p_pkg::KIND_LPAREN: begin
            push_en   = 1'b1;
            state_nxt = S_TAIL;
          end
          i2p_pkg::KIND_RPAREN: begin
            if (!stack_empty && (top_code != i2p_pkg::OP_LPAREN)) begin
              state_nxt = S_POPCH;
            end else begin
              if (!stack_empty) begin
                count_nxt = top_pos;
              end
              state_nxt = S_TAIL;
            end
          end
          i2p_pkg::KIND_OP: begin
            if (!stack_empty && (top_code != i2p_pkg::OP_LPAREN) &&
                (prec_of(top_code) >= prec_of(cur_r.op))) begin
              state_nxt = S_POPCH;
            end else begin
              push_en   = 1'b1;
              state_nxt = S_TAIL;
            end
          end
          default: state_nxt = S_TAIL;
        endcase
      end
      S_POPCH: begin
        emit_req  = 1'b1;
        emit_char = code_char(top_code);
        if (proceed) begin
          count_nxt = top_pos;
          state_nxt = S_POPSP;
        end
      end
      S_POPSP: begin
        emit_req = 1'b1;
        if (proceed) begin
          state_nxt = flush_r ? S_FLUSH : S_BODY;
        end
      end
      S_TAIL: begin
        if (!cur_r.last) begin
          state_nxt = S_IDLE;
        end else begin
          emit_req = tok_open_r;
          if (proceed) begin
            tok_open_nxt = 1'b0;
            flush_nxt    = 1'b1;
            state_nxt    = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stack_empty) begin
          state_nxt = S_POPCH;
        end else begin
          emit_req  = 1'b1;
          emit_term = 1'b1;
          emit_char = i2p_pkg::CH_NUL;
          if (proceed) begin
            count_nxt    = '0;
            tok_open_nxt = 1'b0;
            ovf_nxt      = 1'b0;
            flush_nxt    = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (push_en) begin
      if (count_r >= DEPTH_C) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (load && !emit_term) begin
      ecnt_nxt = ecnt_r + ECNT_W'(1);
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_eoe_nxt   = out_eoe_r;
    out_ovf_nxt   = out_ovf_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_eoe_nxt   = emit_term;
      out_ovf_nxt   = emit_term && ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && (count_r < DEPTH_C)) begin
      stack_mem[count_r[IDX_W-1:0]] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ecnt_r     <= ecnt_nxt;
    out_char_r <= out_char_nxt;
    out_eoe_r  <= out_eoe_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tok_open_r  <= 1'b0;
      ovf_r       <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tok_open_r  <= tok_open_nxt;
      ovf_r       <= ovf_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_char_out          = out_char_r;
  assign out_end_of_expression = out_eoe_r;
  assign out_stack_overflow    = out_ovf_r;

endmodule

`default_nettype wire

// ===== rtl/i2p_checker.sv =====
// Port-level checks for the infix to postfix converter, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module i2p_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char_out,
  input wire logic       out_end_of_expression,
  input wire logic       out_stack_overflow
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_char_out) && $stable(out_end_of_expression) &&
      $stable(out_stack_overflow))
    else $error("stalled result changed or was withdrawn");

  // The overflow flag only rides on the terminator.
  a_ovf_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_expression |-> !out_stack_overflow)
    else $error("overflow flag on a character result");

  // The terminator carries a zero character.
  a_term_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_expression |-> (out_char_out == 8'h00))
    else $error("terminator with nonzero character");

  // Reset leaves no result on offer.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_char_out          (out_char_out),
  .out_end_of_expression (out_end_of_expression),
  .out_stack_overflow    (out_stack_overflow)
);

`default_nettype wire

// ===== test/tb_infix_to_postfix_converter.sv =====
// Testbench for infix_to_postfix_converter: directed and random infix character streams,
// with every postfix character checked against a shunting-yard scoreboard.
// Depends on i2p_pkg and the infix_to_postfix_converter top level.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;
  import i2p_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 470;
  // Worst case is roughly 500 requests, each flushing a full stack, with every result
  // stalled by the receiver; this bound sits several times above that.
  localparam int CYCLE_LIMIT  = 600000;
  // Sized to cover a full flush of the stack, with stalls on top.
  localparam int DRAIN_CYCLES = 150;

  // Character classes that the package does not name.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // One postfix output symbol: a character, or the terminator with its overflow flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       ovf;
  } postfix_sym_t;

  // The scoreboard keeps its own copy of the operator stack and token state. Each accepted
  // character request is converted at once into the postfix symbols it must produce, and
  // those symbols wait in order for the result channel.
  class postfix_scoreboard;
    logic [2:0]   op_stack [DEPTH];
    int unsigned  op_count;
    bit           token_open;
    bit           ovf_seen;
    int           step_syms;
    int           mismatches;
    postfix_sym_t postfix_q [$];

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      for (int i = 0; i < DEPTH; i++) op_stack[i] = OP_NONE;
      op_count   = 0;
      token_open = 1'b0;
      ovf_seen   = 1'b0;
    endfunction

    // One request yields at most MAX_RESULTS symbols; the last slot is kept for the terminator.
    function void put_sym(logic [7:0] ch, logic eoe, logic ovf);
      postfix_sym_t s;
      if (step_syms >= MAX_RESULTS) return;
      if (!eoe && step_syms >= MAX_RESULTS - 1) return;
      s = '{ch: ch, eoe: eoe, ovf: ovf};
      postfix_q.push_back(s);
      step_syms++;
    endfunction

    function logic [7:0] op_char(logic [2:0] code);
      case (code)
        OP_LPAREN: return CH_LPAREN;
        OP_PLUS:   return CH_PLUS;
        OP_MINUS:  return CH_MINUS;
        OP_TIMES:  return CH_TIMES;
        OP_DIVIDE: return CH_DIVIDE;
        default:   return CH_NUL;
      endcase
    endfunction

    function logic [2:0] op_of(logic [7:0] c);
      case (c)
        CH_PLUS:   return OP_PLUS;
        CH_MINUS:  return OP_MINUS;
        CH_TIMES:  return OP_TIMES;
        CH_DIVIDE: return OP_DIVIDE;
        default:   return OP_NONE;
      endcase
    endfunction

    function int prec(logic [2:0] code);
      if (code == OP_PLUS || code == OP_MINUS) return 1;
      if (code == OP_TIMES || code == OP_DIVIDE) return 2;
      return 0;
    endfunction

    function logic [2:0] top_op();
      if (op_count == 0) return OP_NONE;
      return op_stack[op_count - 1];
    endfunction

    function void pop_op();
      logic [2:0] code;
      code = top_op();
      if (op_count == 0) return;
      op_count--;
      put_sym(op_char(code), 1'b0, 1'b0);
      put_sym(CH_SPACE, 1'b0, 1'b0);
    endfunction

    function void push_op(logic [2:0] code);
      if (op_count >= DEPTH) begin
        ovf_seen = 1'b1;
        return;
      end
      op_stack[op_count] = code;
      op_count++;
    endfunction

    function void close_token();
      if (token_open) begin
        put_sym(CH_SPACE, 1'b0, 1'b0);
        token_open = 1'b0;
      end
    endfunction

    // Notes an accepted character request and queues the symbols it causes.
    function void note_char(logic [7:0] c, logic last);
      logic [2:0] code;
      bit         is_space;
      bit         is_tok;
      step_syms = 0;
      is_space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      is_tok    = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                  (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_DOT);
      code      = op_of(c);
      if (is_space) begin
        close_token();
      end else if (is_tok) begin
        put_sym(c, 1'b0, 1'b0);
        token_open = 1'b1;
      end else begin
        close_token();
        if (c == CH_LPAREN) begin
          push_op(OP_LPAREN);
        end else if (c == CH_RPAREN) begin
          while (op_count != 0 && top_op() != OP_LPAREN) pop_op();
          if (op_count != 0) op_count--;
        end else if (code != OP_NONE) begin
          while (op_count != 0 && top_op() != OP_LPAREN && prec(top_op()) >= prec(code))
            pop_op();
          push_op(code);
        end
      end
      if (last) begin
        close_token();
        while (op_count != 0) pop_op();
        put_sym(CH_NUL, 1'b1, ovf_seen);
        clear_state();
      end
    endfunction

    function void report(string what, postfix_sym_t want, postfix_sym_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected char=%02h eoe=%0b ovf=%0b, got char=%02h eoe=%0b ovf=%0b",
                 what, want.ch, want.eoe, want.ovf, got.ch, got.eoe, got.ovf);
    endfunction

    // Checks one accepted result against the oldest waiting symbol.
    function void check_char(logic [7:0] ch, logic eoe, logic ovf);
      postfix_sym_t got;
      postfix_sym_t want;
      got = '{ch: ch, eoe: eoe, ovf: ovf};
      if (postfix_q.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = postfix_q.pop_front();
        if (got.ch !== want.ch || got.eoe !== want.eoe || got.ovf !== want.ovf)
          report("wrong result", want, got);
      end
    endfunction

    function int pending();
      return postfix_q.size();
    endfunction
  endclass

  // Every block input starts at a known value.
  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_char_in   = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char_out;
  logic       out_end_of_expression;
  logic       out_stack_overflow;

  postfix_scoreboard sb;
  logic [7:0]        expr_q [$];
  int                send_idle_pct = 37;
  int                recv_idle_pct = 53;
  int                cycles        = 0;
  int                random_sent   = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_in           (in_char_in),
    .in_last_char         (in_last_char),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_char_out         (out_char_out),
    .out_end_of_expression(out_end_of_expression),
    .out_stack_overflow   (out_stack_overflow)
  );

  always #6 clk = ~clk;

  // The receiver stalls at random in the share of cycles that the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Both channels are sampled at the clock edge, before any of this edge's updates land.
  // Accepted character requests feed the scoreboard; accepted results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_char_in, in_last_char);
      if (out_valid && !out_stall)
        sb.check_char(out_char_out, out_end_of_expression, out_stack_overflow);
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter: mismatch");
      $finish;
    end
  end

  // Offers one character request, after a random idle gap, and holds it while in_stall is high.
  // Valid is only lowered during a gap, so it never drops and rises within one step.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= c;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the built expression with the last flag on its final character.
  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) send_char(expr_q[i], i == expr_q.size() - 1);
    expr_q.delete();
  endtask

  function automatic logic [7:0] rand_token_char();
    case ($urandom_range(3))
      0:       return CH_ZERO + 8'($urandom_range(9));
      1:       return CH_UPPER_A + 8'($urandom_range(25));
      2:       return CH_LOWER_A + 8'($urandom_range(25));
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] rand_op_char();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      default: return CH_DIVIDE;
    endcase
  endfunction

  function automatic logic [7:0] rand_space_char();
    if ($urandom_range(5) == 0) return CH_TAB + 8'($urandom_range(4));
    return CH_SPACE;
  endfunction

  task automatic add_token();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) expr_q.push_back(rand_token_char());
  endtask

  // A well-formed expression with random tokens, spacing and nesting. A few keep an
  // unmatched open parenthesis, and a sprinkle of raw bytes breaks some of them.
  task automatic build_wellformed();
    int terms;
    int open_cnt;
    terms    = $urandom_range(1, 7);
    open_cnt = 0;
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(3) == 0) expr_q.push_back(rand_space_char());
      while ($urandom_range(2) == 0 && open_cnt < 6) begin
        expr_q.push_back(CH_LPAREN);
        open_cnt++;
      end
      add_token();
      if ($urandom_range(3) == 0) expr_q.push_back(rand_space_char());
      while (open_cnt > 0 && $urandom_range(2) == 0) begin
        expr_q.push_back(CH_RPAREN);
        open_cnt--;
      end
      if (i < terms - 1) expr_q.push_back(rand_op_char());
    end
    if ($urandom_range(9) != 0) begin
      while (open_cnt > 0) begin
        expr_q.push_back(CH_RPAREN);
        open_cnt--;
      end
    end
    if ($urandom_range(4) == 0) expr_q.push_back(rand_space_char());
    for (int i = 0; i < expr_q.size(); i++)
      if ($urandom_range(99) < 4) expr_q[i] = 8'($urandom_range(255));
  endtask

  // Deep nesting that can fill the operator stack, and often pushes past it.
  task automatic build_deep();
    int n;
    n = $urandom_range(10, 20);
    repeat (n) begin
      expr_q.push_back(CH_LPAREN);
      if ($urandom_range(1) == 0) begin
        add_token();
        expr_q.push_back(rand_op_char());
      end
    end
    add_token();
    repeat ($urandom_range(0, 4)) begin
      expr_q.push_back(CH_RPAREN);
      if ($urandom_range(1) == 0) begin
        expr_q.push_back(rand_op_char());
        add_token();
      end
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 12)) expr_q.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    int pick;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every token class edge, each operator, parentheses, whitespace,
    // bytes that are neither, an unmatched close, an unmatched open at the final
    // flush, and the last flag on a byte that is otherwise ignored.
    send_char(CH_LOWER_A, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_NINE, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_UPPER_Z, 1'b0);
    send_char(CH_TIMES, 1'b0);
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_LOWER_Z, 1'b0);
    send_char(CH_RPAREN, 1'b0);
    send_char(CH_DIVIDE, 1'b0);
    send_char(CH_UPPER_A, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_RPAREN, 1'b0);
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_NUL, 1'b1);
    send_char(CH_CR, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_ZERO + 8'd7, 1'b1);

    // Random part in three idle settings: receiver-heavy stalls, sender-heavy gaps,
    // then full speed on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (random_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          build_wellformed();
        end else if (pick < 88) begin
          build_deep();
        end else begin
          build_noise();
        end
        random_sent += expr_q.size();
        send_expr();
      end
    end
    in_valid <= 1'b0;

    // Wait for every queued symbol, then a little longer to catch any stray result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("infix_to_postfix_converter: match");
    end else begin
      $display("infix_to_postfix_converter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2p_pkg.sv
rtl/i2p_front.sv
rtl/i2p_cmdq.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter.sv
rtl/i2p_checker.sv
test/tb_infix_to_postfix_converter.sv
